### rtl/hlle_pkg.sv
package hlle_pkg;

  // Default pool size and fixed field widths.
  localparam int unsigned MAX_NODES_DEF = 64;
  localparam int unsigned OP_W          = 3;
  localparam int unsigned HANDLE_W      = 7;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned STATUS_W      = 2;

  // Operation codes carried by the input transaction.
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR      = 3'd0,
    OP_INS_AFTER  = 3'd1,
    OP_INS_BEFORE = 3'd2,
    OP_ERASE      = 3'd3,
    OP_DUMP       = 3'd4
  } op_e;

  // Status codes carried by the output transaction.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  // Microprogram addresses.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_INS_CHK,
    S_INS_FULL,
    S_INS_AB,
    S_INS_W1,
    S_INS_W2,
    S_ERS_CHK,
    S_ERS_AB,
    S_ERS_W,
    S_DMP_CHK,
    S_DMP_EMIT,
    S_DMP_EMPTY,
    S_FAIL_BAD,
    S_FAIL_FULL,
    S_NOP
  } step_e;

  // Jump conditions tested by a control word.
  typedef enum logic [2:0] {
    C_NONE,
    C_DISPATCH,
    C_BAD_ANCHOR,
    C_BAD_ERASE,
    C_FULL,
    C_EMPTY,
    C_MORE
  } cond_e;

  // Link table read address source.
  typedef enum logic [1:0] {
    RD_NONE,
    RD_HANDLE,
    RD_HEAD,
    RD_CHAIN
  } rd_e;

  // Datapath actions.
  typedef enum logic [2:0] {
    DP_NONE,
    DP_CLEAR,
    DP_LATCH_INS,
    DP_INS_NODE,
    DP_INS_LINK,
    DP_LATCH_ERS,
    DP_ERS_LINK,
    DP_DUMP_START
  } dp_e;

  // Kind of result written into the output register.
  typedef enum logic [2:0] {
    EM_NONE,
    EM_ACK,
    EM_NEW,
    EM_VALUE,
    EM_EMPTY,
    EM_BAD,
    EM_FULL
  } emit_e;

  // One control word of the microprogram.
  typedef struct packed {
    cond_e cond;
    step_e target;
    step_e nxt;
    rd_e   rd;
    dp_e   dp;
    emit_e emit;
  } uword_t;

  function automatic uword_t mk_uword(cond_e c, step_e t, step_e n, rd_e r, dp_e d, emit_e e);
    uword_t w;
    w.cond   = c;
    w.target = t;
    w.nxt    = n;
    w.rd     = r;
    w.dp     = d;
    w.emit   = e;
    return w;
  endfunction

  // Control store: taken jump goes to target, otherwise to nxt.
  function automatic uword_t ucode(step_e s);
    uword_t w;
    case (s)
      S_IDLE:      w = mk_uword(C_DISPATCH, S_IDLE, S_IDLE, RD_NONE, DP_NONE, EM_NONE);
      S_CLR:       w = mk_uword(C_NONE, S_IDLE, S_IDLE, RD_NONE, DP_CLEAR, EM_ACK);
      S_INS_CHK:   w = mk_uword(C_BAD_ANCHOR, S_FAIL_BAD, S_INS_FULL, RD_NONE, DP_NONE,
                                EM_NONE);
      S_INS_FULL:  w = mk_uword(C_FULL, S_FAIL_FULL, S_INS_AB, RD_HANDLE, DP_NONE, EM_NONE);
      S_INS_AB:    w = mk_uword(C_NONE, S_IDLE, S_INS_W1, RD_NONE, DP_LATCH_INS, EM_NONE);
      S_INS_W1:    w = mk_uword(C_NONE, S_IDLE, S_INS_W2, RD_NONE, DP_INS_NODE, EM_NONE);
      S_INS_W2:    w = mk_uword(C_NONE, S_IDLE, S_IDLE, RD_NONE, DP_INS_LINK, EM_NEW);
      S_ERS_CHK:   w = mk_uword(C_BAD_ERASE, S_FAIL_BAD, S_ERS_AB, RD_HANDLE, DP_NONE,
                                EM_NONE);
      S_ERS_AB:    w = mk_uword(C_NONE, S_IDLE, S_ERS_W, RD_NONE, DP_LATCH_ERS, EM_NONE);
      S_ERS_W:     w = mk_uword(C_NONE, S_IDLE, S_IDLE, RD_NONE, DP_ERS_LINK, EM_ACK);
      S_DMP_CHK:   w = mk_uword(C_EMPTY, S_DMP_EMPTY, S_DMP_EMIT, RD_HEAD, DP_DUMP_START,
                                EM_NONE);
      S_DMP_EMIT:  w = mk_uword(C_MORE, S_DMP_EMIT, S_IDLE, RD_CHAIN, DP_NONE, EM_VALUE);
      S_DMP_EMPTY: w = mk_uword(C_NONE, S_IDLE, S_IDLE, RD_NONE, DP_NONE, EM_EMPTY);
      S_FAIL_BAD:  w = mk_uword(C_NONE, S_IDLE, S_IDLE, RD_NONE, DP_NONE, EM_BAD);
      S_FAIL_FULL: w = mk_uword(C_NONE, S_IDLE, S_IDLE, RD_NONE, DP_NONE, EM_FULL);
      S_NOP:       w = mk_uword(C_NONE, S_IDLE, S_IDLE, RD_NONE, DP_NONE, EM_ACK);
      default:     w = mk_uword(C_NONE, S_IDLE, S_IDLE, RD_NONE, DP_NONE, EM_NONE);
    endcase
    return w;
  endfunction

  // Entry point of the microprogram for each operation.
  function automatic step_e dispatch(logic [OP_W-1:0] op);
    step_e s;
    case (op)
      OP_CLEAR:      s = S_CLR;
      OP_INS_AFTER:  s = S_INS_CHK;
      OP_INS_BEFORE: s = S_INS_CHK;
      OP_ERASE:      s = S_ERS_CHK;
      OP_DUMP:       s = S_DMP_CHK;
      default:       s = S_NOP;
    endcase
    return s;
  endfunction

endpackage

### rtl/hlle_in_if.sv
interface hlle_in_if import hlle_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            operation;
  logic [HANDLE_W-1:0]        handle;
  logic signed [VALUE_W-1:0]  item_value;

  modport source (output valid, operation, handle, item_value, input ready);
  modport sink   (input valid, operation, handle, item_value, output ready);
endinterface

### rtl/hlle_out_if.sv
interface hlle_out_if import hlle_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  out_value;
  logic [HANDLE_W-1:0]        new_handle;
  logic [STATUS_W-1:0]        status;
  logic                       empty_list;
  logic                       last;

  modport source (output valid, out_value, new_handle, status, empty_list, last,
                  input ready);
  modport sink   (input valid, out_value, new_handle, status, empty_list, last,
                  output ready);
endinterface

### rtl/handle_linked_list_engine_top.sv
// Channel | Dir | Payload                                          | Transactions
// in_i    | in  | operation, handle, item_value                    | one per operation
// out_o   | out | out_value, new_handle, status, empty_list, last  | one per op, N per dump
//
// A microcoded sequencer runs one operation at a time; input is taken in the idle step.
// Insert steps through anchor check, pool check, link latch and two table writes; erase
// through its check, link latch and one write; failures, clear and unknown ops emit directly.
// Dump emits one result per listed node, or one empty result; the walk is paced
// by the registered link table read.
// Reset is asynchronous; it clears the head links and live bits and sets the handle counter to one.
// A full output register stalls the sequencer on its emitting step until it is taken.
module handle_linked_list_engine_top
  import hlle_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  hlle_in_if.sink        in_i,
  hlle_out_if.source     out_o
);

  localparam int unsigned IW = $clog2(MAX_NODES + 1);
  localparam int unsigned CW = $clog2(MAX_NODES + 2);
  localparam int unsigned KW = $clog2(MAX_NODES);

  // Sequencer and control state.
  step_e                 step_q, step_d;
  uword_t                uw;
  logic [CW-1:0]         n_q, n_d;
  logic [KW-1:0]         k_q, k_d;
  logic [IW-1:0]         head_next_q, head_next_d;
  logic [IW-1:0]         head_prev_q, head_prev_d;
  logic [MAX_NODES:0]    alive_q, alive_d;
  logic                  out_valid_q, out_valid_d;

  // Operand and work registers.
  logic [OP_W-1:0]            op_q;
  logic [HANDLE_W-1:0]        h_q;
  logic signed [VALUE_W-1:0]  val_q;
  logic [IW-1:0]              a_q, a_d;
  logic [IW-1:0]              b_q, b_d;

  // Output register payload.
  logic signed [VALUE_W-1:0]  out_value_q, out_value_d;
  logic [HANDLE_W-1:0]        new_handle_q, new_handle_d;
  logic [STATUS_W-1:0]        status_q, status_d;
  logic                       empty_q, empty_d;
  logic                       last_q, last_d;

  // Link and value tables.
  logic [IW-1:0]              next_mem [0:MAX_NODES];
  logic [IW-1:0]              prev_mem [0:MAX_NODES];
  logic signed [VALUE_W-1:0]  val_mem  [0:MAX_NODES];
  logic [IW-1:0]              nxt_rd_q, prv_rd_q;
  logic signed [VALUE_W-1:0]  val_rd_q;
  logic                       rd_head_q;

  logic                       next_we, prev_we, val_we;
  logic [IW-1:0]              next_wa, next_wd, prev_wa, prev_wd, val_wa;
  logic [IW-1:0]              rd_addr;
  logic                       rd_en;

  logic                       accept, emit_busy, go, cond_hit;
  logic                       anchor_ok, pool_full, dump_last;
  logic [IW-1:0]              h_idx, n_idx, nxt_link, prv_link;

  assign uw        = ucode(step_q);
  assign h_idx     = h_q[IW-1:0];
  assign n_idx     = n_q[IW-1:0];

  // Head entry lives in registers; other entries come from the tables.
  assign nxt_link  = rd_head_q ? head_next_q : nxt_rd_q;
  assign prv_link  = rd_head_q ? head_prev_q : prv_rd_q;

  // Handle checks; a handle below the counter is within the pool.
  assign anchor_ok = (h_q == '0) || ((h_q < HANDLE_W'(n_q)) && alive_q[h_idx]);
  assign pool_full = (n_q > CW'(MAX_NODES));
  assign dump_last = (nxt_link == '0) || (k_q == KW'(MAX_NODES - 1));

  // Handshakes.
  assign in_i.ready = (step_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign emit_busy  = out_valid_q && !out_o.ready;
  assign go         = (uw.emit == EM_NONE) || !emit_busy;

  // Jump condition select.
  always_comb begin
    case (uw.cond)
      C_BAD_ANCHOR: cond_hit = !anchor_ok;
      C_BAD_ERASE:  cond_hit = (h_q == '0) || !anchor_ok;
      C_FULL:       cond_hit = pool_full;
      C_EMPTY:      cond_hit = (head_next_q == '0);
      C_MORE:       cond_hit = !dump_last;
      default:      cond_hit = 1'b0;
    endcase
  end

  // Step counter with conditional jumps.
  always_comb begin
    step_d = step_q;
    if (uw.cond == C_DISPATCH) begin
      if (accept) begin
        step_d = dispatch(in_i.operation);
      end
    end else if (go) begin
      step_d = cond_hit ? uw.target : uw.nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // Table read address.
  always_comb begin
    case (uw.rd)
      RD_HANDLE: rd_addr = h_idx;
      RD_HEAD:   rd_addr = head_next_q;
      RD_CHAIN:  rd_addr = nxt_link;
      default:   rd_addr = '0;
    endcase
  end
  assign rd_en = go && (uw.rd != RD_NONE);

  // Datapath actions selected by the control word.
  always_comb begin
    next_we     = 1'b0;
    next_wa     = '0;
    next_wd     = '0;
    prev_we     = 1'b0;
    prev_wa     = '0;
    prev_wd     = '0;
    val_we      = 1'b0;
    val_wa      = '0;
    a_d         = a_q;
    b_d         = b_q;
    n_d         = n_q;
    k_d         = k_q;
    alive_d     = alive_q;
    head_next_d = head_next_q;
    head_prev_d = head_prev_q;
    if (go) begin
      case (uw.dp)
        DP_CLEAR: begin
          alive_d     = '0;
          n_d         = CW'(1);
          head_next_d = '0;
          head_prev_d = '0;
        end
        DP_LATCH_INS: begin
          if (op_q == OP_INS_AFTER) begin
            a_d = h_idx;
            b_d = nxt_link;
          end else begin
            a_d = prv_link;
            b_d = h_idx;
          end
        end
        DP_INS_NODE: begin
          next_we = 1'b1;
          next_wa = n_idx;
          next_wd = b_q;
          prev_we = 1'b1;
          prev_wa = n_idx;
          prev_wd = a_q;
          val_we  = 1'b1;
          val_wa  = n_idx;
        end
        DP_INS_LINK: begin
          next_we        = 1'b1;
          next_wa        = a_q;
          next_wd        = n_idx;
          prev_we        = 1'b1;
          prev_wa        = b_q;
          prev_wd        = n_idx;
          alive_d[n_idx] = 1'b1;
          n_d            = n_q + CW'(1);
        end
        DP_LATCH_ERS: begin
          a_d = prv_link;
          b_d = nxt_link;
        end
        DP_ERS_LINK: begin
          next_we        = 1'b1;
          next_wa        = a_q;
          next_wd        = b_q;
          prev_we        = 1'b1;
          prev_wa        = b_q;
          prev_wd        = a_q;
          alive_d[h_idx] = 1'b0;
        end
        DP_DUMP_START: begin
          k_d = '0;
        end
        default: begin
        end
      endcase
      if (uw.emit == EM_VALUE) begin
        k_d = k_q + KW'(1);
      end
      // Writes to the head entry land in the head registers.
      if (next_we && (next_wa == '0)) begin
        head_next_d = next_wd;
      end
      if (prev_we && (prev_wa == '0)) begin
        head_prev_d = prev_wd;
      end
    end
  end

  // Output register load.
  always_comb begin
    out_valid_d  = out_valid_q && !out_o.ready;
    out_value_d  = out_value_q;
    new_handle_d = new_handle_q;
    status_d     = status_q;
    empty_d      = empty_q;
    last_d       = last_q;
    if (go && (uw.emit != EM_NONE)) begin
      out_valid_d  = 1'b1;
      out_value_d  = '0;
      new_handle_d = '0;
      status_d     = ST_OK;
      empty_d      = 1'b0;
      last_d       = 1'b1;
      case (uw.emit)
        EM_NEW:   new_handle_d = HANDLE_W'(n_q);
        EM_VALUE: begin
          out_value_d = val_rd_q;
          last_d      = dump_last;
        end
        EM_EMPTY: empty_d  = 1'b1;
        EM_BAD:   status_d = ST_BAD;
        EM_FULL:  status_d = ST_FULL;
        default: begin
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= CW'(1);
      k_q         <= '0;
      head_next_q <= '0;
      head_prev_q <= '0;
      alive_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      n_q         <= n_d;
      k_q         <= k_d;
      head_next_q <= head_next_d;
      head_prev_q <= head_prev_d;
      alive_q     <= alive_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= in_i.operation;
      h_q   <= in_i.handle;
      val_q <= in_i.item_value;
    end
    a_q          <= a_d;
    b_q          <= b_d;
    out_value_q  <= out_value_d;
    new_handle_q <= new_handle_d;
    status_q     <= status_d;
    empty_q      <= empty_d;
    last_q       <= last_d;
  end

  // Tables: one write port each, registered read.
  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (val_we) begin
      val_mem[val_wa] <= val_q;
    end
    if (rd_en) begin
      nxt_rd_q  <= next_mem[rd_addr];
      prv_rd_q  <= prev_mem[rd_addr];
      val_rd_q  <= val_mem[rd_addr];
      rd_head_q <= (rd_addr == '0);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_value  = out_value_q;
  assign out_o.new_handle = new_handle_q;
  assign out_o.status     = status_q;
  assign out_o.empty_list = empty_q;
  assign out_o.last       = last_q;

  // The sequencer must not move past an emitting step while the output is full.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
      ((uw.emit != EM_NONE) && emit_busy) |=> (step_q == $past(step_q)))
    else $error("sequencer advanced while output stalled");

  // The handle counter stays within the pool plus one.
  a_counter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (n_q >= CW'(1)) && (n_q <= CW'(MAX_NODES + 1)))
    else $error("handle counter out of range");

  // When the head's next link is empty, its previous link is empty too.
  a_head_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (head_next_q == '0) |-> (head_prev_q == '0))
    else $error("head links disagree on an empty list");

  // A granted handle is never beyond the pool.
  a_new_handle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_q |-> (new_handle_q <= HANDLE_W'(MAX_NODES)))
    else $error("new handle beyond pool");

  // An empty dump result is a single, error-free transaction.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && empty_q) |-> (last_q && (status_q == ST_OK)))
    else $error("malformed empty dump result");

endmodule
